FILE: src/cqr_pkg.sv
// cqr_pkg: shared types and constants of the circular queue with reverse
// no dependencies; imported by cqr_wrap, circular_queue_with_reverse and cqr_checker

package cqr_pkg;

  localparam int DATA_W = 32;
  localparam int CAP_W  = 5;
  localparam int ACT_W  = 2;
  localparam int STAT_W = 2;

  localparam logic [ACT_W-1:0] ACT_ENQ = 2'd0;
  localparam logic [ACT_W-1:0] ACT_DEQ = 2'd1;
  localparam logic [ACT_W-1:0] ACT_REV = 2'd2;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // control of the shared wrapping index unit
  typedef struct packed {
    logic             step_down;
    logic [CAP_W-1:0] cap;
  } wrap_ctl_t;

endpackage

FILE: src/cqr_ram.sv
// cqr_ram: generic simple dual-port ram, one write and one registered read
// no dependencies

module cqr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: src/cqr_wrap.sv
// cqr_wrap: shared index unit, steps a ring index up or down modulo the capacity
// depends on cqr_pkg

module cqr_wrap #(
  parameter int IDX_W = 4
) (
  input  logic               [IDX_W-1:0] idx_i,
  input  cqr_pkg::wrap_ctl_t             ctl_i,
  output logic               [IDX_W-1:0] idx_o
);

  import cqr_pkg::*;

  localparam int SUM_W = ((IDX_W > CAP_W) ? IDX_W : CAP_W) + 1;

  logic [SUM_W-1:0] idx_x;
  logic [SUM_W-1:0] cap_x;
  logic [SUM_W-1:0] inc_x;
  logic [SUM_W-1:0] dec_x;
  logic [SUM_W-1:0] top_x;

  always_comb begin
    idx_x = SUM_W'(idx_i);
    cap_x = SUM_W'(ctl_i.cap);
    inc_x = idx_x + SUM_W'(1);
    dec_x = idx_x - SUM_W'(1);
    top_x = cap_x - SUM_W'(1);
    if (ctl_i.step_down) begin
      idx_o = (idx_x == '0) ? top_x[IDX_W-1:0] : dec_x[IDX_W-1:0];
    end else begin
      idx_o = (inc_x >= cap_x) ? '0 : inc_x[IDX_W-1:0];
    end
  end

endmodule

FILE: src/circular_queue_with_reverse.sv
// circular_queue_with_reverse: ring-buffer queue of signed words with reverse
// depends on cqr_pkg, cqr_ram, cqr_wrap
//
//  channel   signals                                          direction
//  in        in_valid/in_ready, in_action, in_push_value      request in
//  out       out_valid/out_ready, out_pop_value, out_status,   result out
//            out_fill_count
//  cfg       cfg_we, cfg_data (capacity)                      write only
//
// enqueue and dequeue pass S_PUSH or S_POP, then S_FINISH, and a no-op or a reverse
// of fewer than two words only S_FINISH; a longer reverse runs S_REV_INIT, then
// floor(n/2) swaps, each two reads and two writes through the single read port
// of the slot ram, with the shared index unit stepping the two ends
// rst_n is synchronous; the result register lets a new request in while the
// last result waits, and a finished request holds until that register frees

module circular_queue_with_reverse #(
  parameter int DEPTH = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic        [cqr_pkg::CAP_W-1:0]   cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic        [cqr_pkg::ACT_W-1:0]   in_action,
  input  logic signed [cqr_pkg::DATA_W-1:0]  in_push_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [cqr_pkg::DATA_W-1:0]  out_pop_value,
  output logic        [cqr_pkg::STAT_W-1:0]  out_status,
  output logic        [cqr_pkg::CAP_W-1:0]   out_fill_count
);

  import cqr_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CAP_MAX = (DEPTH < 31) ? DEPTH : 31;
  localparam logic [CAP_W-1:0] CAP_MAX_V = CAP_W'(CAP_MAX);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_PUSH     = 9'b000000010,
    S_POP      = 9'b000000100,
    S_REV_INIT = 9'b000001000,
    S_RD_LO    = 9'b000010000,
    S_RD_HI    = 9'b000100000,
    S_WR_LO    = 9'b001000000,
    S_WR_HI    = 9'b010000000,
    S_FINISH   = 9'b100000000
  } state_t;

  function automatic logic [CAP_W-1:0] cap_sat(input logic [CAP_W-1:0] v);
    if (v == '0) begin
      return CAP_W'(1);
    end else if (v > CAP_MAX_V) begin
      return CAP_MAX_V;
    end else begin
      return v;
    end
  endfunction

  state_t               state_r, state_nxt;
  logic [CAP_W-1:0]     cap_r, cap_nxt;
  logic [IDX_W-1:0]     head_r, head_nxt;
  logic [IDX_W-1:0]     tail_r, tail_nxt;
  logic [CAP_W-1:0]     count_r, count_nxt;
  logic [IDX_W-1:0]     lo_r, lo_nxt;
  logic [IDX_W-1:0]     hi_r, hi_nxt;
  logic [CAP_W-2:0]     pairs_r, pairs_nxt;
  logic [DATA_W-1:0]    val_r, val_nxt;
  logic [DATA_W-1:0]    hold_r, hold_nxt;
  logic [DATA_W-1:0]    pop_r, pop_nxt;
  status_t              status_r, status_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]    out_pop_r, out_pop_nxt;
  status_t              out_status_r, out_status_nxt;
  logic [CAP_W-1:0]     out_fill_r, out_fill_nxt;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [DATA_W-1:0]    ram_wdata;
  logic [IDX_W-1:0]     ram_raddr;
  logic [DATA_W-1:0]    ram_rdata;

  logic [IDX_W-1:0]     unit_idx;
  wrap_ctl_t            unit_ctl;
  logic [IDX_W-1:0]     unit_out;

  cqr_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  cqr_wrap #(
    .IDX_W (IDX_W)
  ) u_wrap (
    .idx_i (unit_idx),
    .ctl_i (unit_ctl),
    .idx_o (unit_out)
  );

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    cap_nxt        = cap_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    pairs_nxt      = pairs_r;
    val_nxt        = val_r;
    hold_nxt       = hold_r;
    pop_nxt        = pop_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r;
    out_pop_nxt    = out_pop_r;
    out_status_nxt = out_status_r;
    out_fill_nxt   = out_fill_r;

    ram_we             = 1'b0;
    ram_waddr          = tail_r;
    ram_wdata          = val_r;
    ram_raddr          = head_r;
    unit_idx           = head_r;
    unit_ctl.step_down = 1'b0;
    unit_ctl.cap       = cap_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        // read at head is issued here so a dequeue finds its word next cycle
        if (in_valid) begin
          val_nxt    = in_push_value;
          pop_nxt    = '0;
          status_nxt = ST_DONE;
          unique case (in_action)
            ACT_ENQ: state_nxt = S_PUSH;
            ACT_DEQ: state_nxt = S_POP;
            ACT_REV: begin
              pairs_nxt = count_r[CAP_W-1:1];
              state_nxt = (count_r >= CAP_W'(2)) ? S_REV_INIT : S_FINISH;
            end
            default: state_nxt = S_FINISH;
          endcase
        end
      end
      S_PUSH: begin
        if (count_r >= cap_r) begin
          status_nxt = ST_FULL;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = tail_r;
          ram_wdata = val_r;
          unit_idx  = tail_r;
          tail_nxt  = unit_out;
          count_nxt = count_r + CAP_W'(1);
        end
        state_nxt = S_FINISH;
      end
      S_POP: begin
        if (count_r == '0) begin
          status_nxt = ST_EMPTY;
        end else begin
          pop_nxt   = ram_rdata;
          count_nxt = count_r - CAP_W'(1);
          unit_idx  = head_r;
          // last word out rewinds both ends
          if (count_r == CAP_W'(1)) begin
            head_nxt = '0;
            tail_nxt = '0;
          end else begin
            head_nxt = unit_out;
          end
        end
        state_nxt = S_FINISH;
      end
      S_REV_INIT: begin
        unit_idx           = tail_r;
        unit_ctl.step_down = 1'b1;
        hi_nxt             = unit_out;
        lo_nxt             = head_r;
        state_nxt          = S_RD_LO;
      end
      S_RD_LO: begin
        ram_raddr = lo_r;
        state_nxt = S_RD_HI;
      end
      S_RD_HI: begin
        ram_raddr = hi_r;
        hold_nxt  = ram_rdata;
        state_nxt = S_WR_LO;
      end
      S_WR_LO: begin
        ram_we    = 1'b1;
        ram_waddr = lo_r;
        ram_wdata = ram_rdata;
        unit_idx  = lo_r;
        lo_nxt    = unit_out;
        state_nxt = S_WR_HI;
      end
      S_WR_HI: begin
        ram_we             = 1'b1;
        ram_waddr          = hi_r;
        ram_wdata          = hold_r;
        unit_idx           = hi_r;
        unit_ctl.step_down = 1'b1;
        hi_nxt             = unit_out;
        pairs_nxt          = pairs_r - (CAP_W-1)'(1);
        state_nxt          = (pairs_r == (CAP_W-1)'(1)) ? S_FINISH : S_RD_LO;
      end
      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_pop_nxt    = pop_r;
          out_status_nxt = status_r;
          out_fill_nxt   = count_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // capacity write empties the queue
    if (cfg_we) begin
      cap_nxt   = cap_sat(cfg_data);
      head_nxt  = '0;
      tail_nxt  = '0;
      count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cap_r       <= cap_sat(CAP_RESET);
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cap_r       <= cap_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    pairs_r      <= pairs_nxt;
    val_r        <= val_nxt;
    hold_r       <= hold_nxt;
    pop_r        <= pop_nxt;
    status_r     <= status_nxt;
    out_pop_r    <= out_pop_nxt;
    out_status_r <= out_status_nxt;
    out_fill_r   <= out_fill_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_pop_value  = out_pop_r;
  assign out_status     = out_status_r;
  assign out_fill_count = out_fill_r;

endmodule

FILE: src/cqr_checker.sv
// cqr_checker: port-level assertions on the circular queue, bound to the top level
// depends on cqr_pkg and circular_queue_with_reverse

module cqr_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [cqr_pkg::DATA_W-1:0]  out_pop_value,
  input logic        [cqr_pkg::STAT_W-1:0]  out_status,
  input logic        [cqr_pkg::CAP_W-1:0]   out_fill_count
);

  import cqr_pkg::*;

  // a waiting result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");

  // an accepted request keeps the input closed on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted on back-to-back cycles");

  // a rejected enqueue returns no word
  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL) |-> (out_pop_value == '0))
    else $error("full rejection carries a word");

  // an empty rejection reports an empty queue and no word
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_EMPTY) |-> (out_fill_count == '0) && (out_pop_value == '0))
    else $error("empty rejection with words held or a word returned");

  // no result leaves straight out of reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

endmodule

bind circular_queue_with_reverse cqr_checker u_cqr_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_pop_value  (out_pop_value),
  .out_status     (out_status),
  .out_fill_count (out_fill_count)
);
